// ===== design/vtrf_pkg.sv =====
package vtrf_pkg;

  localparam int BUDGET_W = 22;
  localparam int CNT_W = $clog2(BUDGET_W + 1);

  localparam int DEF_NTSC_FRAME_CYCLES = 1562500;
  localparam int DEF_PAL_FRAME_CYCLES = 1875000;
  localparam int DEF_SERRATE_BIT = 6;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 112;

  localparam logic [31:0] STATUS_RESET = 32'h0000_000F;
  localparam logic [10:0] LINE_WIDTH_RESET = 11'd320;
  localparam logic [9:0] INTR_LINE_RESET = 10'd256;
  localparam logic [8:0] HALFLINES_RESET = 9'd262;
  localparam logic [31:0] HALFLINE_CYCLES_RESET = 32'd1000;
  localparam logic [1:0] ONE_FIELD = 2'd1;
  localparam logic [1:0] TWO_FIELDS = 2'd2;

  localparam int RAW_WORDS = 7;

  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [3:0] REG_STATUS = 4'd0;
  localparam logic [3:0] REG_ORIGIN = 4'd1;
  localparam logic [3:0] REG_WIDTH = 4'd2;
  localparam logic [3:0] REG_INTR = 4'd3;
  localparam logic [3:0] REG_CURRENT = 4'd4;
  localparam logic [3:0] REG_BURST = 4'd5;
  localparam logic [3:0] REG_VSYNC = 4'd6;
  localparam logic [3:0] REG_HSYNC = 4'd7;
  localparam logic [3:0] REG_LEAP = 4'd8;
  localparam logic [3:0] REG_LAST = 4'd13;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

endpackage

// ===== design/video_timing_register_file_unit.sv =====
// Channel  | Ports                         | Contents (lowest bit first)
// ---------+-------------------------------+-----------------------------------------------
// in       | s_tvalid s_tready s_tdata     | reg_index[3:0] write_data[35:4]
//          | s_tuser                       | current_line[45:36]; tuser: cmd
// out      | m_tvalid m_tready m_tdata     | read_data, irq_clear, fields_per_frame,
//          | m_tuser                       | halflines, cycles_per_halfline, divide_error,
//          |                               | origin_changes; tuser: access_error
// config   | cfg_wen cfg_wdata             | pal_mode
//
// Most accesses give a valid result in the cycle after acceptance.
// A vsync write with nonzero halflines produces one quotient bit per
// cycle from the shared restoring subtractor and takes no new item meanwhile.
// Synchronous reset restores the register file and clears the output valid.
// A waiting result blocks new items only until it is taken.
module video_timing_register_file_unit #(
  parameter int NTSC_FRAME_CYCLES = vtrf_pkg::DEF_NTSC_FRAME_CYCLES,
  parameter int PAL_FRAME_CYCLES = vtrf_pkg::DEF_PAL_FRAME_CYCLES,
  parameter int SERRATE_BIT = vtrf_pkg::DEF_SERRATE_BIT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // reg_index, write_data, current_line, zero pad
  input  logic [vtrf_pkg::S_TDATA_W-1:0]   s_tdata,
  // cmd
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data, irq_clear, fields_per_frame, halflines, cycles_per_halfline,
  // divide_error, origin_changes, zero pad
  output logic [vtrf_pkg::M_TDATA_W-1:0]   m_tdata,
  // access_error
  output logic                             m_tuser,
  input  logic                             cfg_wen,
  input  logic                             cfg_wdata
);
  import vtrf_pkg::*;

  localparam logic [BUDGET_W-1:0] NTSC_BUDGET = BUDGET_W'(NTSC_FRAME_CYCLES);
  localparam logic [BUDGET_W-1:0] PAL_BUDGET = BUDGET_W'(PAL_FRAME_CYCLES);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(BUDGET_W - 1);

  state_t state, state_next;

  logic        pal_mode;
  logic [31:0] status_word;
  logic [23:0] fb_origin;
  logic [10:0] line_width;
  logic [9:0]  intr_line;
  logic [9:0]  vsync_value;
  logic [9:0]  hsync_value;
  logic [31:0] raw_words [RAW_WORDS];
  logic [31:0] swap_counter;
  logic [1:0]  field_count;
  logic [8:0]  halfline_count;
  logic [31:0] halfline_cycles;

  logic [31:0] out_rd;
  logic        out_err;
  logic        out_irq;
  logic        out_derr;

  logic [CNT_W-1:0]    cnt;
  logic [8:0]          rem;
  logic [BUDGET_W-1:0] quo;

  logic        accept;
  logic        div_busy;
  logic        div_done;
  logic        cmd;
  logic [3:0]  idx;
  logic [31:0] wdata;
  logic [9:0]  cur;
  logic        bad_idx;
  logic        raw_hit;
  logic [2:0]  raw_slot;
  logic [8:0]  new_halflines;
  logic        div_start;
  logic [31:0] rd_value;

  logic [9:0]          trial;
  logic [9:0]          diff;
  logic                q_bit;
  logic [8:0]          rem_next;
  logic [BUDGET_W-1:0] quo_next;

  assign cmd   = s_tuser;
  assign idx   = s_tdata[3:0];
  assign wdata = s_tdata[35:4];
  assign cur   = s_tdata[45:36];

  assign bad_idx = (idx > REG_LAST);
  assign raw_hit = (idx == REG_BURST) || ((idx >= REG_LEAP) && !bad_idx);
  assign raw_slot = (idx == REG_BURST) ? 3'd0 : 3'(idx - 4'd7);
  assign new_halflines = wdata[9:1];
  assign accept = s_tvalid && s_tready;
  assign div_start = accept && (cmd == CMD_WRITE) && (idx == REG_VSYNC)
                     && (new_halflines != 9'd0);

  // Shared restoring divide step.
  assign trial = {rem, quo[BUDGET_W-1]};
  assign diff = trial - {1'b0, halfline_count};
  assign q_bit = (trial >= {1'b0, halfline_count});
  assign rem_next = q_bit ? diff[8:0] : trial[8:0];
  assign quo_next = {quo[BUDGET_W-2:0], q_bit};
  assign div_done = div_busy && (cnt == LAST_STEP);

  always_comb begin
    rd_value = 32'd0;
    case (idx)
      REG_STATUS:  rd_value = status_word;
      REG_ORIGIN:  rd_value = {8'd0, fb_origin};
      REG_WIDTH:   rd_value = {21'd0, line_width};
      REG_INTR:    rd_value = {22'd0, intr_line};
      REG_CURRENT: rd_value = {21'd0, cur, 1'b0};
      REG_VSYNC:   rd_value = {22'd0, vsync_value};
      REG_HSYNC:   rd_value = {22'd0, hsync_value};
      default: begin
        if (raw_hit) begin
          rd_value = raw_words[raw_slot];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == LAST_STEP) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    div_busy = 1'b0;
    case (state)
      ST_IDLE: s_tready = !m_tvalid || m_tready;
      ST_DIV:  div_busy = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_mode        <= 1'b0;
      status_word     <= STATUS_RESET;
      fb_origin       <= 24'd0;
      line_width      <= LINE_WIDTH_RESET;
      intr_line       <= INTR_LINE_RESET;
      vsync_value     <= 10'd0;
      hsync_value     <= 10'd0;
      for (int i = 0; i < RAW_WORDS; i++) begin
        raw_words[i] <= 32'd0;
      end
      swap_counter    <= 32'd0;
      field_count     <= ONE_FIELD;
      halfline_count  <= HALFLINES_RESET;
      halfline_cycles <= HALFLINE_CYCLES_RESET;
      m_tvalid        <= 1'b0;
      cnt             <= '0;
    end else begin
      if (cfg_wen) begin
        pal_mode <= cfg_wdata;
      end
      if (accept) begin
        m_tvalid <= !div_start;
      end else if (div_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        out_err  <= bad_idx;
        out_irq  <= (cmd == CMD_WRITE) && (idx == REG_CURRENT);
        out_derr <= (cmd == CMD_WRITE) && (idx == REG_VSYNC) && (new_halflines == 9'd0);
        if (bad_idx) begin
          out_rd <= 32'd0;
        end else if (cmd == CMD_READ) begin
          out_rd <= rd_value;
        end else begin
          out_rd <= 32'd0;
          case (idx)
            REG_STATUS: begin
              status_word <= wdata;
              field_count <= wdata[SERRATE_BIT] ? TWO_FIELDS : ONE_FIELD;
            end
            REG_ORIGIN: begin
              if (wdata[23:0] != fb_origin) begin
                swap_counter <= swap_counter + 32'd1;
              end
              fb_origin <= wdata[23:0];
            end
            REG_WIDTH:   line_width <= wdata[10:0];
            REG_INTR:    intr_line <= wdata[9:0];
            REG_VSYNC: begin
              vsync_value    <= wdata[9:0];
              halfline_count <= new_halflines;
              rem            <= 9'd0;
              quo            <= pal_mode ? PAL_BUDGET : NTSC_BUDGET;
              cnt            <= '0;
            end
            REG_HSYNC: hsync_value <= wdata[9:0];
            default: begin
              if (raw_hit) begin
                raw_words[raw_slot] <= wdata;
              end
            end
          endcase
        end
      end
      if (div_busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + CNT_W'(1);
        if (div_done) begin
          halfline_cycles <= 32'(quo_next);
        end
      end
    end
  end

  assign m_tdata = {3'd0, swap_counter, out_derr, halfline_cycles, halfline_count,
                    field_count, out_irq, out_rd};
  assign m_tuser = out_err;

endmodule
